@@ rtl/krt_pkg.sv @@
package krt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_UPDATE = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DUP     = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [30:0]        part_key;
        logic signed [31:0] new_quantity;
    } krt_req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] quantity_out;
        logic [5:0]         slot_out;
        logic [6:0]         entries_now;
    } krt_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       scan;
        logic       fetch;
        logic       write;
        logic       emit;
        logic [1:0] code;
    } krt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] op;
        logic       hit;
        logic       exhausted;
        logic       full;
        logic       out_free;
    } krt_stat_t;

endpackage

@@ rtl/krt_ctrl.sv @@
module krt_ctrl
    import krt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  krt_stat_t stat,
    output krt_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FETCH,
        S_WRITE,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] code_reg;
    logic [1:0] code_next;

    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.hit)
                begin
                    code_next = ST_OK;
                    case (stat.op)
                        OP_INSERT:
                        begin
                            code_next  = ST_DUP;
                            state_next = S_DONE;
                        end
                        OP_DELETE: state_next = S_FETCH;
                        OP_LOOKUP: state_next = S_FETCH;
                        OP_UPDATE: state_next = S_WRITE;
                        default:   state_next = S_DONE;
                    endcase
                end
                else if (stat.exhausted)
                begin
                    if (stat.op == OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            code_next  = ST_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            code_next  = ST_OK;
                            state_next = S_WRITE;
                        end
                    end
                    else
                    begin
                        code_next  = ST_MISSING;
                        state_next = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                // delete moves the last record down; lookup just reads
                state_next = (stat.op == OP_DELETE) ? S_WRITE : S_DONE;
            end
            S_WRITE:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    assign req_stall   = (state_reg != S_IDLE);
    assign cmd.capture = (state_reg == S_IDLE) && req_valid;
    assign cmd.scan    = (state_reg == S_SCAN);
    assign cmd.fetch   = (state_reg == S_FETCH);
    assign cmd.write   = (state_reg == S_WRITE);
    assign cmd.emit    = (state_reg == S_DONE) && stat.out_free;
    assign cmd.code    = code_reg;

endmodule

@@ rtl/krt_datapath.sv @@
module krt_datapath
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  krt_req_t  req,
    input  logic      rsp_stall,
    output logic      rsp_valid,
    output krt_rsp_t  rsp,
    input  krt_cmd_t  cmd,
    output krt_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [30:0]        key_mem [DEPTH];
    logic signed [31:0] qty_mem [DEPTH];

    krt_req_t           req_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      scan_addr_reg;
    logic [AW-1:0]      hit_slot_reg;
    logic [AW-1:0]      rd_slot_reg;
    logic               rd_vld_reg;
    logic [30:0]        key_rd_reg;
    logic signed [31:0] qty_rd_reg;
    logic               rsp_valid_reg;
    krt_rsp_t           rsp_reg;

    logic               hit;
    logic               issue;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      last_slot;
    logic [CW-1:0]      last_count;
    logic               key_wr_en;
    logic               qty_wr_en;
    logic [AW-1:0]      wr_addr;
    logic [30:0]        wr_key;
    logic signed [31:0] wr_qty;
    logic [31:0]        slot_wide;
    logic [31:0]        count_wide;
    logic               ok;

    assign hit        = rd_vld_reg && (key_rd_reg == req_reg.part_key);
    assign issue      = cmd.scan && !hit && (scan_addr_reg != count_reg);
    assign last_count = count_reg - CW'(1);
    assign last_slot  = last_count[AW-1:0];
    assign rd_en      = issue || cmd.fetch;

    always_comb
    begin
        if (cmd.fetch)
        begin
            rd_addr = (req_reg.op == OP_DELETE) ? last_slot : hit_slot_reg;
        end
        else
        begin
            rd_addr = scan_addr_reg[AW-1:0];
        end
    end

    // write port: insert appends, update rewrites the quantity, delete copies the last record into the hole
    always_comb
    begin
        key_wr_en  = 1'b0;
        qty_wr_en  = 1'b0;
        wr_addr    = hit_slot_reg;
        wr_key     = req_reg.part_key;
        wr_qty     = req_reg.new_quantity;
        count_next = count_reg;
        if (cmd.write)
        begin
            case (req_reg.op)
                OP_INSERT:
                begin
                    key_wr_en  = 1'b1;
                    qty_wr_en  = 1'b1;
                    wr_addr    = count_reg[AW-1:0];
                    count_next = count_reg + CW'(1);
                end
                OP_DELETE:
                begin
                    key_wr_en  = 1'b1;
                    qty_wr_en  = 1'b1;
                    wr_key     = key_rd_reg;
                    wr_qty     = qty_rd_reg;
                    count_next = last_count;
                end
                OP_UPDATE:
                begin
                    qty_wr_en = 1'b1;
                end
                default:
                begin
                    key_wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (key_wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
        end
        if (rd_en)
        begin
            key_rd_reg <= key_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (qty_wr_en)
        begin
            qty_mem[wr_addr] <= wr_qty;
        end
        if (rd_en)
        begin
            qty_rd_reg <= qty_mem[rd_addr];
        end
    end

    assign ok         = (cmd.code == ST_OK);
    assign slot_wide  = 32'(hit_slot_reg);
    assign count_wide = 32'(count_reg);

    function automatic krt_rsp_t rsp_next();
        krt_rsp_t r;
        r.status       = cmd.code;
        r.quantity_out = (ok && (req_reg.op == OP_LOOKUP)) ? qty_rd_reg : 32'sd0;
        r.slot_out     = ok ? slot_wide[5:0] : 6'd0;
        r.entries_now  = count_wide[6:0];
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (issue)
        begin
            rd_slot_reg <= scan_addr_reg[AW-1:0];
        end
        if (cmd.scan && hit)
        begin
            hit_slot_reg <= rd_slot_reg;
        end
        else if (cmd.write && (req_reg.op == OP_INSERT))
        begin
            hit_slot_reg <= count_reg[AW-1:0];
        end
        if (cmd.emit)
        begin
            rsp_reg <= rsp_next();
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            scan_addr_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.capture)
            begin
                scan_addr_reg <= '0;
            end
            else if (issue)
            begin
                scan_addr_reg <= scan_addr_reg + CW'(1);
            end
            rd_vld_reg <= issue;
            if (cmd.emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.op        = req_reg.op;
    assign stat.hit       = hit;
    assign stat.exhausted = !rd_vld_reg && (scan_addr_reg == count_reg);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/keyed_record_table.sv @@
// Unsorted key/quantity table, one request at a time.
// The response waits on the serial key scan (one memory read per cycle) over the live
// records; a hit ends the scan early. The next request is taken only back in idle,
// and it can be taken while the response waits in the output register.
// Reset clears the live count and control only; no clearing pass over the stores.
module keyed_record_table
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  krt_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output krt_rsp_t rsp
);

    krt_cmd_t  cmd;
    krt_stat_t stat;

    krt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    krt_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

@@ bench/krt_checker.sv @@
`timescale 1ns / 100ps

module krt_checker
    import krt_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    input  logic     req_stall,
    input  krt_req_t req,
    input  logic     rsp_valid,
    input  logic     rsp_stall,
    input  krt_rsp_t rsp,
    output int       fail_count,
    output int       pending
);

    localparam int REPORT_LIMIT = 10;

    krt_rsp_t           expected_rsps[$];
    logic [30:0]        table_keys [DEPTH];
    logic signed [31:0] table_qty [DEPTH];
    int                 live_entries = 0;
    int                 mismatches = 0;
    int                 waiting = 0;

    assign fail_count = mismatches;
    assign pending    = waiting;

    // Applies one request to the shadow table and returns the response it should give.
    function automatic krt_rsp_t apply_table_op(input krt_req_t r);
        krt_rsp_t           o;
        int                 hit;
        int                 last;
        logic [30:0]        tk;
        logic signed [31:0] tq;
        o = '0;
        o.status = ST_OK;
        hit = -1;
        for (int i = 0; i < live_entries; i++)
        begin
            if (hit < 0 && table_keys[i] == r.part_key)
                hit = i;
        end
        case (r.op)
            OP_INSERT:
            begin
                if (hit >= 0)
                    o.status = ST_DUP;
                else if (live_entries >= DEPTH)
                    o.status = ST_FULL;
                else
                begin
                    o.slot_out = 6'(live_entries);
                    table_keys[live_entries] = r.part_key;
                    table_qty[live_entries]  = r.new_quantity;
                    live_entries++;
                end
            end
            OP_DELETE:
            begin
                if (hit < 0)
                    o.status = ST_MISSING;
                else
                begin
                    last = live_entries - 1;
                    tk = table_keys[last];
                    tq = table_qty[last];
                    table_keys[last] = table_keys[hit];
                    table_qty[last]  = table_qty[hit];
                    table_keys[hit]  = tk;
                    table_qty[hit]   = tq;
                    live_entries--;
                    o.slot_out = 6'(hit);
                end
            end
            OP_LOOKUP:
            begin
                if (hit < 0)
                    o.status = ST_MISSING;
                else
                begin
                    o.quantity_out = table_qty[hit];
                    o.slot_out = 6'(hit);
                end
            end
            default:
            begin
                if (hit < 0)
                    o.status = ST_MISSING;
                else
                begin
                    table_qty[hit] = r.new_quantity;
                    o.slot_out = 6'(hit);
                end
            end
        endcase
        o.entries_now = 7'(live_entries);
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        krt_rsp_t want;
        if (!rst_n)
        begin
            live_entries = 0;
            expected_rsps.delete();
            waiting <= 0;
        end
        else
        begin
            // response first: it always belongs to an older request
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected response: status=%0d qty=%0d slot=%0d count=%0d",
                                 rsp.status, rsp.quantity_out, rsp.slot_out, rsp.entries_now);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp.status !== want.status || rsp.quantity_out !== want.quantity_out ||
                        rsp.slot_out !== want.slot_out || rsp.entries_now !== want.entries_now)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("mismatch: expected status=%0d qty=%0d slot=%0d count=%0d, got status=%0d qty=%0d slot=%0d count=%0d",
                                     want.status, want.quantity_out, want.slot_out,
                                     want.entries_now, rsp.status, rsp.quantity_out,
                                     rsp.slot_out, rsp.entries_now);
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_rsps.push_back(apply_table_op(req));
            waiting <= expected_rsps.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import krt_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_ITEMS = 600;
    localparam int PHASE_ITEMS  = 150;
    localparam int POOL_SIZE    = 72;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 4000;

    localparam logic [30:0]        KEY_MAX = 31'h7FFF_FFFF;
    localparam logic signed [31:0] QTY_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] QTY_MAX = 32'sh7FFF_FFFF;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     req_valid;
    logic     req_stall;
    krt_req_t req;
    logic     rsp_valid;
    logic     rsp_stall;
    krt_rsp_t rsp;
    int       fail_count;
    int       pending;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    bit          hold_off_request = 1'b0;
    logic [30:0] key_pool [POOL_SIZE];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    keyed_record_table #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    krt_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_req(input krt_req_t item);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Each 200-item cycle: fill toward full, then mixed traffic, then drain.
    function automatic krt_req_t table_traffic(input int idx);
        krt_req_t r;
        int       pos;
        int       pick;
        pos  = idx % 200;
        pick = $urandom_range(99);
        if (pos < 120)
            r.op = (pick < 85) ? OP_INSERT : (pick < 88) ? OP_DELETE :
                   (pick < 94) ? OP_LOOKUP : OP_UPDATE;
        else if (pos < 160)
            r.op = (pick < 25) ? OP_INSERT : (pick < 50) ? OP_DELETE :
                   (pick < 75) ? OP_LOOKUP : OP_UPDATE;
        else
            r.op = (pick < 70) ? OP_DELETE : (pick < 80) ? OP_INSERT :
                   (pick < 90) ? OP_LOOKUP : OP_UPDATE;
        // mostly pool keys so searches hit; some fresh keys that miss
        if ($urandom_range(9) == 0)
            r.part_key = 31'($urandom());
        else
            r.part_key = key_pool[$urandom_range(POOL_SIZE - 1)];
        case ($urandom_range(15))
            0:       r.new_quantity = QTY_MIN;
            1:       r.new_quantity = QTY_MAX;
            2:       r.new_quantity = '0;
            default: r.new_quantity = $urandom();
        endcase
        return r;
    endfunction

    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        req_valid <= 1'b0;
        req <= '0;
        key_pool[0] = '0;
        key_pool[1] = KEY_MAX;
        for (int k = 2; k < POOL_SIZE; k++)
            key_pool[k] = 31'($urandom());
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: every search misses
        send_req(krt_req_t'{OP_LOOKUP, 31'd0, 32'($urandom())});
        send_req(krt_req_t'{OP_DELETE, KEY_MAX, 32'($urandom())});
        send_req(krt_req_t'{OP_UPDATE, 31'd0, QTY_MAX});
        send_req(krt_req_t'{OP_INSERT, 31'd0, QTY_MIN});
        send_req(krt_req_t'{OP_INSERT, KEY_MAX, QTY_MAX});
        // duplicate insert leaves the table alone
        send_req(krt_req_t'{OP_INSERT, 31'd0, 32'sd0});
        send_req(krt_req_t'{OP_LOOKUP, 31'd0, 32'($urandom())});
        send_req(krt_req_t'{OP_LOOKUP, KEY_MAX, 32'($urandom())});
        send_req(krt_req_t'{OP_UPDATE, KEY_MAX, -32'sd1});
        send_req(krt_req_t'{OP_LOOKUP, KEY_MAX, 32'sd0});
        send_req(krt_req_t'{OP_INSERT, 31'h2AAA_AAAA, 32'sh5555_5555});
        send_req(krt_req_t'{OP_INSERT, 31'h5555_5555, 32'shAAAA_AAAA});
        // delete from slot 0 pulls the last record down
        send_req(krt_req_t'{OP_DELETE, 31'd0, 32'($urandom())});
        send_req(krt_req_t'{OP_LOOKUP, 31'h5555_5555, 32'sd0});
        send_req(krt_req_t'{OP_LOOKUP, 31'd0, 32'sd0});
        // last live record swaps with itself
        send_req(krt_req_t'{OP_DELETE, 31'h2AAA_AAAA, 32'sd0});
        send_req(krt_req_t'{OP_LOOKUP, 31'h2AAA_AAAA, 32'sd0});
        send_req(krt_req_t'{OP_DELETE, KEY_MAX, 32'sd0});
        send_req(krt_req_t'{OP_DELETE, 31'h5555_5555, 32'sd0});
        send_req(krt_req_t'{OP_DELETE, 31'h5555_5555, 32'sd0});
        send_req(krt_req_t'{OP_UPDATE, KEY_MAX, QTY_MIN});

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % PHASE_ITEMS == 0)
            begin
                case (i / PHASE_ITEMS)
                    0:
                    begin
                        send_idle_pct = 0;
                        stall_pct = 0;
                        hold_off_request = 1'b1;
                    end
                    1:
                    begin
                        send_idle_pct = 55;
                        stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct = 0;
                        stall_pct = 55;
                    end
                    default:
                    begin
                        send_idle_pct = 36;
                        stall_pct = 36;
                    end
                endcase
            end
            send_req(table_traffic(i));
        end
        req_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 10) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
